FILE: hw/rtl/rrts_pkg.sv
// shared types, constants and helpers for the round-robin thread slot scheduler
package rrts_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int ACTION_W   = 2;
  localparam int JOIN_ID_W  = 4;
  localparam int STATUS_W   = 2;
  localparam int OUT_SLOT_W = 3;
  localparam int LIVE_W     = 4;

  localparam logic [LIVE_W-1:0] LIVE_MAX = '1;

  typedef logic [SLOT_W-1:0] slot_idx_t;

  typedef enum logic [1:0] {
    SL_UNUSED   = 2'd0,
    SL_READY    = 2'd1,
    SL_RUNNING  = 2'd2,
    SL_FINISHED = 2'd3
  } slot_st_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CREATE = 2'd0,
    ACT_YIELD  = 2'd1,
    ACT_EXIT   = 2'd2,
    ACT_JOIN   = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_FREE = 2'd1,
    STAT_BAD_ID  = 2'd2,
    STAT_WAIT    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    AS_CUR,
    AS_SCAN,
    AS_JOIN
  } addr_sel_t;

  // controller to datapath, one cycle's worth of work
  typedef struct packed {
    logic      latch;
    addr_sel_t addr_sel;
    logic      wr_en;
    slot_st_t  wr_state;
    logic      scan_zero;
    logic      scan_from_cur;
    logic      scan_inc;
    logic      live_inc;
    logic      live_dec;
    logic      take_new;
    logic      take_run;
    logic      set_switched;
    logic      set_none;
    logic      set_status;
    status_t   status;
    logic      emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    slot_st_t rd_state;
    action_t  action;
    logic     join_bad;
    logic     scan_at_cur;
    logic     scan_last;
  } dp_stat_t;

  // round-robin successor of a slot index
  function automatic slot_idx_t next_slot(input slot_idx_t s);
    slot_idx_t r;
    if (s == slot_idx_t'(SLOT_COUNT - 1)) begin
      r = '0;
    end else begin
      r = s + 1'b1;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/rrts_datapath.sv
// slot table, running slot, live count and result registers
module rrts_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rrts_pkg::dp_cmd_t                   cmd,
  output rrts_pkg::dp_stat_t                  stat,
  input  logic [rrts_pkg::ACTION_W-1:0]       in_action,
  input  logic [rrts_pkg::JOIN_ID_W-1:0]      in_join_id,
  output logic                                out_valid,
  output logic [rrts_pkg::STATUS_W-1:0]       out_status,
  output logic [rrts_pkg::OUT_SLOT_W-1:0]     out_new_slot,
  output logic [rrts_pkg::OUT_SLOT_W-1:0]     out_running_slot,
  output logic                                out_switched,
  output logic                                out_none_ready,
  output logic [rrts_pkg::LIVE_W-1:0]         out_live_count
);
  import rrts_pkg::*;

  slot_st_t                 slot_state_r [SLOT_COUNT];
  slot_idx_t                run_r;
  slot_idx_t                scan_r;
  logic [LIVE_W-1:0]        live_r;
  action_t                  action_r;
  logic [JOIN_ID_W-1:0]     join_id_r;
  status_t                  status_r;
  slot_idx_t                new_slot_r;
  logic                     switched_r;
  logic                     none_r;
  logic                     valid_r;

  slot_idx_t                addr;
  logic                     addr_ok;
  slot_st_t                 rd_state;

  always_comb begin
    case (cmd.addr_sel)
      AS_CUR:  addr = run_r;
      AS_SCAN: addr = scan_r;
      AS_JOIN: addr = slot_idx_t'(join_id_r);
      default: addr = run_r;
    endcase
  end

  assign addr_ok  = (int'(addr) < SLOT_COUNT);
  assign rd_state = addr_ok ? slot_state_r[addr] : SL_UNUSED;

  assign stat.rd_state    = rd_state;
  assign stat.action      = action_r;
  assign stat.join_bad    = (int'(join_id_r) >= SLOT_COUNT);
  assign stat.scan_at_cur = (scan_r == run_r);
  assign stat.scan_last   = (scan_r == slot_idx_t'(SLOT_COUNT - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_state_r[i] <= (i == 0) ? SL_RUNNING : SL_UNUSED;
      end
      run_r   <= '0;
      live_r  <= LIVE_W'(1);
      valid_r <= 1'b0;
    end else begin
      if (cmd.wr_en && addr_ok) begin
        slot_state_r[addr] <= cmd.wr_state;
      end
      if (cmd.take_run) begin
        run_r <= scan_r;
      end
      if (cmd.live_inc && (live_r != LIVE_MAX)) begin
        live_r <= live_r + 1'b1;
      end else if (cmd.live_dec && (live_r != '0)) begin
        live_r <= live_r - 1'b1;
      end
      valid_r <= cmd.emit;
    end
  end

  // request capture, scan pointer and per-request result fields
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      action_r   <= action_t'(in_action);
      join_id_r  <= in_join_id;
      status_r   <= STAT_OK;
      new_slot_r <= '0;
      switched_r <= 1'b0;
      none_r     <= 1'b0;
    end else begin
      if (cmd.set_status) begin
        status_r <= cmd.status;
      end
      if (cmd.take_new) begin
        new_slot_r <= scan_r;
      end
      if (cmd.set_switched) begin
        switched_r <= 1'b1;
      end
      if (cmd.set_none) begin
        none_r <= 1'b1;
      end
    end
    if (cmd.scan_zero) begin
      scan_r <= '0;
    end else if (cmd.scan_from_cur) begin
      scan_r <= next_slot(run_r);
    end else if (cmd.scan_inc) begin
      scan_r <= next_slot(scan_r);
    end
  end

  assign out_valid        = valid_r;
  assign out_status       = status_r;
  assign out_new_slot     = OUT_SLOT_W'(new_slot_r);
  assign out_running_slot = OUT_SLOT_W'(run_r);
  assign out_switched     = switched_r;
  assign out_none_ready   = none_r;
  assign out_live_count   = live_r;

endmodule

FILE: hw/rtl/rrts_ctrl.sv
// sequencing state machine for create, yield, exit and join
module rrts_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rrts_pkg::dp_stat_t stat,
  output rrts_pkg::dp_cmd_t  cmd
);
  import rrts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_CREATE_SCAN,
    S_EXIT_MARK,
    S_DEMOTE,
    S_SCAN,
    S_RESTORE,
    S_RESP
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;

  always_comb begin
    cmd       = '0;
    cmd.addr_sel = AS_CUR;
    cmd.wr_state = SL_UNUSED;
    cmd.status   = STAT_OK;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.action)
          ACT_CREATE: begin
            cmd.scan_zero = 1'b1;
            state_nxt     = S_CREATE_SCAN;
          end
          ACT_YIELD: state_nxt = S_DEMOTE;
          ACT_EXIT:  state_nxt = S_EXIT_MARK;
          ACT_JOIN: begin
            cmd.addr_sel = AS_JOIN;
            if (stat.join_bad) begin
              cmd.set_status = 1'b1;
              cmd.status     = STAT_BAD_ID;
              state_nxt      = S_RESP;
            end else if (stat.rd_state inside {SL_UNUSED, SL_FINISHED}) begin
              cmd.wr_en    = 1'b1;
              cmd.wr_state = SL_UNUSED;
              state_nxt    = S_RESP;
            end else begin
              cmd.set_status = 1'b1;
              cmd.status     = STAT_WAIT;
              state_nxt      = S_DEMOTE;
            end
          end
          default: state_nxt = S_RESP;
        endcase
      end
      S_CREATE_SCAN: begin
        cmd.addr_sel = AS_SCAN;
        if (stat.rd_state == SL_UNUSED) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_state = SL_READY;
          cmd.take_new = 1'b1;
          cmd.live_inc = 1'b1;
          state_nxt    = S_RESP;
        end else if (stat.scan_last) begin
          cmd.set_status = 1'b1;
          cmd.status     = STAT_NO_FREE;
          state_nxt      = S_RESP;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_EXIT_MARK: begin
        if (stat.rd_state inside {SL_RUNNING, SL_READY}) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_state = SL_FINISHED;
          cmd.live_dec = 1'b1;
        end
        state_nxt = S_DEMOTE;
      end
      S_DEMOTE: begin
        // current slot steps down before the search
        if (stat.rd_state == SL_RUNNING) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_state = SL_READY;
        end
        cmd.scan_from_cur = 1'b1;
        state_nxt         = S_SCAN;
      end
      S_SCAN: begin
        cmd.addr_sel = AS_SCAN;
        if (stat.scan_at_cur) begin
          state_nxt = S_RESTORE;
        end else if (stat.rd_state == SL_READY) begin
          cmd.wr_en        = 1'b1;
          cmd.wr_state     = SL_RUNNING;
          cmd.take_run     = 1'b1;
          cmd.set_switched = 1'b1;
          state_nxt        = S_RESP;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_RESTORE: begin
        // nothing else ready: a ready current slot resumes, a dead one stays
        if (stat.rd_state == SL_READY) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_state = SL_RUNNING;
        end
        cmd.set_none = 1'b1;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

FILE: hw/rtl/round_robin_thread_slot_scheduler_unit.sv
// top level of the round-robin thread slot scheduler
// A request (action, join_id) is taken at a clock edge where start is high and busy is low;
// busy then stays high until the request is finished. Exactly one result per request
// appears for a single cycle with out_valid high and must be captured then, since the
// block cannot be stalled. A bad or freeing join goes straight to its result; create does
// one slot read per cycle in the lowest-free search; yield and a waiting join do one slot
// read per cycle in the round-robin search, and exit first retires the current slot and
// then does the same search. A new request can be taken in the cycle that out_valid is
// shown. The slot table sits in a single-port register array with one read and one write
// per cycle.
module round_robin_thread_slot_scheduler_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [rrts_pkg::ACTION_W-1:0]     in_action,
  input  logic [rrts_pkg::JOIN_ID_W-1:0]    in_join_id,
  output logic                              out_valid,
  output logic [rrts_pkg::STATUS_W-1:0]     out_status,
  output logic [rrts_pkg::OUT_SLOT_W-1:0]   out_new_slot,
  output logic [rrts_pkg::OUT_SLOT_W-1:0]   out_running_slot,
  output logic                              out_switched,
  output logic                              out_none_ready,
  output logic [rrts_pkg::LIVE_W-1:0]       out_live_count
);
  import rrts_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rrts_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  rrts_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_action        (in_action),
    .in_join_id       (in_join_id),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_new_slot     (out_new_slot),
    .out_running_slot (out_running_slot),
    .out_switched     (out_switched),
    .out_none_ready   (out_none_ready),
    .out_live_count   (out_live_count)
  );

endmodule

FILE: hw/rtl/rrts_checker.sv
// port-level checks for the scheduler, bound to the top level
module rrts_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_valid,
  input logic [rrts_pkg::STATUS_W-1:0]     out_status,
  input logic [rrts_pkg::OUT_SLOT_W-1:0]   out_new_slot,
  input logic                              out_switched,
  input logic                              out_none_ready,
  input logic [rrts_pkg::LIVE_W-1:0]       out_live_count
);
  import rrts_pkg::*;

  // an accepted request keeps the block busy until its result is out
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted request did not raise busy");

  // a result strobe never comes while busy and lasts one cycle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result strobe outside the end of a request");

  // failed create or bad id leaves scheduling untouched
  a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STAT_NO_FREE || out_status == STAT_BAD_ID))
      |-> (!out_switched && !out_none_ready && out_new_slot == '0))
    else $error("failed request reported a schedule or slot");

  // a switch and an empty search cannot both be reported
  a_switch_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_switched && out_none_ready))
    else $error("switched and none_ready both set");

  // live threads are ready or running slots, never more than the table
  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_live_count) <= SLOT_COUNT))
    else $error("live count above slot count");

endmodule

bind round_robin_thread_slot_scheduler_unit rrts_checker u_rrts_checker (.*);

FILE: dv/tb_top.sv
// self-checking testbench for the round-robin thread slot scheduler
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rrts_pkg::*;

  typedef struct packed {
    status_t                 status;
    logic [OUT_SLOT_W-1:0]   new_slot;
    logic [OUT_SLOT_W-1:0]   run_slot;
    logic                    switched;
    logic                    none_rdy;
    logic [LIVE_W-1:0]       live;
  } sched_res_t;

  typedef struct packed {
    action_t                 act;
    logic [JOIN_ID_W-1:0]    jid;
    logic                    known;
    sched_res_t              res;
  } dir_row_t;

  localparam sched_res_t NOT_TYPED = '0;
  localparam int RAND_REQS = 1000;
  localparam int DRAIN_CYCLES = SLOT_COUNT + 10;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [ACTION_W-1:0]     in_action;
  logic [JOIN_ID_W-1:0]    in_join_id;
  logic                    out_valid;
  logic [STATUS_W-1:0]     out_status;
  logic [OUT_SLOT_W-1:0]   out_new_slot;
  logic [OUT_SLOT_W-1:0]   out_running_slot;
  logic                    out_switched;
  logic                    out_none_ready;
  logic [LIVE_W-1:0]       out_live_count;

  round_robin_thread_slot_scheduler_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_join_id       (in_join_id),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_new_slot     (out_new_slot),
    .out_running_slot (out_running_slot),
    .out_switched     (out_switched),
    .out_none_ready   (out_none_ready),
    .out_live_count   (out_live_count)
  );

  // shadow copy of the scheduler state
  slot_st_t    slot_tbl [SLOT_COUNT];
  int          cur_slot;
  logic [LIVE_W-1:0] live_cnt;

  sched_res_t  pending_res [$];
  dir_row_t    dir_tbl [$];
  int          err_cnt;
  int          results_seen;
  int          act_cnt [4];
  int          stat_cnt [4];
  int          switch_cnt;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_miss(string what, int got, int want);
    $display("mismatch on result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    err_cnt++;
  endtask

  function automatic void clear_slots();
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_tbl[i] = SL_UNUSED;
    end
    slot_tbl[0] = SL_RUNNING;
    cur_slot = 0;
    live_cnt = 1;
  endfunction

  // round-robin pick: demote the running slot, take the next ready one after it
  function automatic void rotate_slots(output logic sw, output logic nr);
    int  n;
    bit  found;
    found = 1'b0;
    sw = 1'b0;
    nr = 1'b1;
    if (slot_tbl[cur_slot] == SL_RUNNING) begin
      slot_tbl[cur_slot] = SL_READY;
    end
    for (int k = 1; k < SLOT_COUNT; k++) begin
      n = (cur_slot + k) % SLOT_COUNT;
      if (!found && slot_tbl[n] == SL_READY) begin
        found = 1'b1;
        slot_tbl[n] = SL_RUNNING;
        cur_slot = n;
        sw = 1'b1;
        nr = 1'b0;
      end
    end
    // a finished or unused current slot is not revived
    if (!found && slot_tbl[cur_slot] == SL_READY) begin
      slot_tbl[cur_slot] = SL_RUNNING;
    end
  endfunction

  function automatic sched_res_t predict_request(action_t act, logic [JOIN_ID_W-1:0] jid);
    sched_res_t r;
    int         free_idx;
    r = '0;
    r.status = STAT_OK;
    case (act)
      ACT_CREATE: begin
        free_idx = -1;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
          if (slot_tbl[i] == SL_UNUSED) free_idx = i;
        end
        if (free_idx >= 0) begin
          slot_tbl[free_idx] = SL_READY;
          r.new_slot = OUT_SLOT_W'(free_idx);
          if (live_cnt < LIVE_MAX) live_cnt++;
        end else begin
          r.status = STAT_NO_FREE;
        end
      end
      ACT_YIELD: begin
        rotate_slots(r.switched, r.none_rdy);
      end
      ACT_EXIT: begin
        if (slot_tbl[cur_slot] == SL_RUNNING || slot_tbl[cur_slot] == SL_READY) begin
          slot_tbl[cur_slot] = SL_FINISHED;
          if (live_cnt > 0) live_cnt--;
        end
        rotate_slots(r.switched, r.none_rdy);
      end
      default: begin
        if (jid >= SLOT_COUNT) begin
          r.status = STAT_BAD_ID;
        end else if (slot_tbl[jid] == SL_FINISHED || slot_tbl[jid] == SL_UNUSED) begin
          slot_tbl[jid] = SL_UNUSED;
        end else begin
          rotate_slots(r.switched, r.none_rdy);
          r.status = STAT_WAIT;
        end
      end
    endcase
    r.run_slot = OUT_SLOT_W'(cur_slot);
    r.live = live_cnt;
    return r;
  endfunction

  // entered at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(action_t act, logic [JOIN_ID_W-1:0] jid, int idle_pct,
                              logic known, sched_res_t typed_res);
    sched_res_t r;
    while ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_action = act;
    in_join_id = jid;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    r = predict_request(act, jid);
    act_cnt[act]++;
    stat_cnt[r.status]++;
    if (r.switched) switch_cnt++;
    pending_res.push_back(known ? typed_res : r);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    sched_res_t want;
    if (rst_n && out_valid) begin
      if (pending_res.size() == 0) begin
        report_miss("unrequested result, status", out_status, 0);
      end else begin
        want = pending_res.pop_front();
        if (out_status !== want.status) report_miss("status", out_status, want.status);
        if (out_new_slot !== want.new_slot) report_miss("new_slot", out_new_slot, want.new_slot);
        if (out_running_slot !== want.run_slot)
          report_miss("running_slot", out_running_slot, want.run_slot);
        if (out_switched !== want.switched)
          report_miss("switched", out_switched, want.switched);
        if (out_none_ready !== want.none_rdy)
          report_miss("none_ready", out_none_ready, want.none_rdy);
        if (out_live_count !== want.live)
          report_miss("live_count", out_live_count, want.live);
      end
      results_seen++;
    end
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_res.size());
    $display("[round_robin_thread_slot_scheduler_unit] ERROR");
    $finish;
  end

  initial begin
    int               idle_pct [3];
    int               pick;
    action_t          act;
    logic [JOIN_ID_W-1:0] jid;
    dir_row_t         row;

    idle_pct = '{0, 68, 6};
    err_cnt = 0;
    results_seen = 0;
    switch_cnt = 0;
    act_cnt = '{0, 0, 0, 0};
    stat_cnt = '{0, 0, 0, 0};
    rst_n = 1'b0;
    start = 1'b0;
    in_action = ACT_CREATE;
    in_join_id = '0;
    clear_slots();

    // directed rows, starting from the reset state
    dir_tbl.push_back({ACT_YIELD,  4'd0,  1'b1, {STAT_OK,      3'd0, 3'd0, 1'b0, 1'b1, 4'd1}});
    dir_tbl.push_back({ACT_JOIN,   4'd15, 1'b1, {STAT_BAD_ID,  3'd0, 3'd0, 1'b0, 1'b0, 4'd1}});
    dir_tbl.push_back({ACT_JOIN,   4'd0,  1'b1, {STAT_WAIT,    3'd0, 3'd0, 1'b0, 1'b1, 4'd1}});
    dir_tbl.push_back({ACT_JOIN,   4'd5,  1'b1, {STAT_OK,      3'd0, 3'd0, 1'b0, 1'b0, 4'd1}});
    // last thread exits, then exit again with nothing live
    dir_tbl.push_back({ACT_EXIT,   4'd0,  1'b1, {STAT_OK,      3'd0, 3'd0, 1'b0, 1'b1, 4'd0}});
    dir_tbl.push_back({ACT_EXIT,   4'd0,  1'b1, {STAT_OK,      3'd0, 3'd0, 1'b0, 1'b1, 4'd0}});
    // free the finished current slot, then schedule from an unused one
    dir_tbl.push_back({ACT_JOIN,   4'd0,  1'b1, {STAT_OK,      3'd0, 3'd0, 1'b0, 1'b0, 4'd0}});
    dir_tbl.push_back({ACT_YIELD,  4'd0,  1'b1, {STAT_OK,      3'd0, 3'd0, 1'b0, 1'b1, 4'd0}});
    dir_tbl.push_back({ACT_CREATE, 4'd0,  1'b1, {STAT_OK,      3'd0, 3'd0, 1'b0, 1'b0, 4'd1}});
    // ready current slot with nothing else ready goes back to running
    dir_tbl.push_back({ACT_YIELD,  4'd0,  1'b0, NOT_TYPED});
    for (int i = 0; i < SLOT_COUNT - 1; i++) begin
      dir_tbl.push_back({ACT_CREATE, 4'(i + 7), 1'b0, NOT_TYPED});
    end
    dir_tbl.push_back({ACT_CREATE, 4'd0,  1'b1, {STAT_NO_FREE, 3'd0, 3'd0, 1'b0, 1'b0, 4'd8}});
    dir_tbl.push_back({ACT_YIELD,  4'd0,  1'b0, NOT_TYPED});
    dir_tbl.push_back({ACT_JOIN,   4'd2,  1'b0, NOT_TYPED});
    dir_tbl.push_back({ACT_EXIT,   4'd0,  1'b0, NOT_TYPED});
    dir_tbl.push_back({ACT_JOIN,   4'd2,  1'b0, NOT_TYPED});
    dir_tbl.push_back({ACT_JOIN,   4'd8,  1'b0, NOT_TYPED});
    dir_tbl.push_back({ACT_CREATE, 4'd0,  1'b0, NOT_TYPED});

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tbl[i]) begin
      row = dir_tbl[i];
      send_request(row.act, row.jid, 0, row.known, row.res);
    end
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      for (int n = 0; n < RAND_REQS / 3; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) act = ACT_CREATE;
        else if (pick < 60) act = ACT_YIELD;
        else if (pick < 78) act = ACT_EXIT;
        else act = ACT_JOIN;
        // mostly in-range ids, some rejected ones
        if ($urandom_range(0, 99) < 85) jid = JOIN_ID_W'($urandom_range(0, SLOT_COUNT - 1));
        else jid = JOIN_ID_W'($urandom_range(SLOT_COUNT, 15));
        send_request(act, jid, idle_pct[ph], 1'b0, NOT_TYPED);
        if ($urandom_range(0, 99) == 0) wait_drained();
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("requests: create %0d, yield %0d, exit %0d, join %0d; %0d results checked",
             act_cnt[ACT_CREATE], act_cnt[ACT_YIELD], act_cnt[ACT_EXIT], act_cnt[ACT_JOIN],
             results_seen);
    $display("status ok %0d, no free %0d, bad id %0d, wait %0d; %0d slot switches",
             stat_cnt[STAT_OK], stat_cnt[STAT_NO_FREE], stat_cnt[STAT_BAD_ID],
             stat_cnt[STAT_WAIT], switch_cnt);
    if (err_cnt == 0 && pending_res.size() == 0) begin
      $display("[round_robin_thread_slot_scheduler_unit] OK");
    end else begin
      $display("[round_robin_thread_slot_scheduler_unit] ERROR");
    end
    $finish;
  end

endmodule
